// ===== src/round_robin_task_scheduler_assert.svh =====
// Assertion macros used by the scheduler port checker.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RRTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, disabled during reset.
`define RRTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

// ===== src/rrts_pkg.sv =====
// Shared types and constants of the round robin task scheduler.
`timescale 1ns / 1ps
package rrts_pkg;

  localparam int TASK_SLOTS  = 8;
  localparam int STACK_BYTES = 1024;
  localparam int FRAME_BYTES = 136;
  localparam int SLOT_W      = $clog2(TASK_SLOTS);
  localparam int OUT_SLOT_W  = 3;
  localparam int CFG_IDX_W   = 2;

  // Request codes
  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // Result status codes
  localparam logic [2:0] STS_CREATED  = 3'd0;
  localparam logic [2:0] STS_FULL     = 3'd1;
  localparam logic [2:0] STS_SWITCHED = 3'd2;
  localparam logic [2:0] STS_STAYED   = 3'd3;
  localparam logic [2:0] STS_STARTED  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TRAMPOLINE = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2
  } task_st_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] entry_addr;
    logic [31:0] outgoing_sp;
  } req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [OUT_SLOT_W-1:0] prev_task;
    logic [31:0]           sp_value;
    logic [31:0]           frame_ra_word;
    logic [31:0]           frame_entry_word;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic read;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic drop;
  } sts_t;

endpackage

// ===== src/rrts_datapath.sv =====
// Task table, stack pointer memory, slot searches and result registers.
`timescale 1ns / 1ps
module rrts_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  rrts_pkg::cmd_t                cmd,
  output rrts_pkg::sts_t                sts,
  input  rrts_pkg::req_t                req,
  output rrts_pkg::rsp_t                rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rrts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import rrts_pkg::*;

  logic [31:0]       stack_base;
  logic [31:0]       trampoline;
  task_st_t          task_state [TASK_SLOTS];
  logic [SLOT_W-1:0] cur;
  logic [31:0]       saved_sp [TASK_SLOTS];

  req_t              req_q;
  logic [2:0]        res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [SLOT_W-1:0] res_prev;
  logic [31:0]       res_addr;
  logic [SLOT_W-1:0] rd_addr;
  logic [31:0]       rd_data;

  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] next_slot;
  logic [31:0]       frame_addr;

  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;

  assign cfg_ready = 1'b1;
  assign sts.drop  = (req_q.req_type == REQ_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_base <= '0;
      trampoline <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_STACK_BASE) begin
        stack_base <= cfg_data;
      end else if (cfg_index == CFG_TRAMPOLINE) begin
        trampoline <= cfg_data;
      end
    end
  end

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (task_state[i] == ST_FREE) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  // Rotating search from the slot after the current one, ending on itself
  always_comb begin
    logic [SLOT_W:0]   sum;
    logic [SLOT_W-1:0] c;
    next_slot = cur;
    for (int n = TASK_SLOTS; n >= 1; n--) begin
      sum = {1'b0, cur} + (SLOT_W + 1)'(n);
      if (sum >= (SLOT_W + 1)'(TASK_SLOTS)) begin
        sum = sum - (SLOT_W + 1)'(TASK_SLOTS);
      end
      c = sum[SLOT_W-1:0];
      if (task_state[c] == ST_READY || task_state[c] == ST_RUNNING) begin
        next_slot = c;
      end
    end
  end

  assign frame_addr = stack_base
                    + (32'(free_slot) + 32'd1) * 32'(STACK_BYTES)
                    - 32'(FRAME_BYTES);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = req_q.outgoing_sp;
    if (cmd.exec) begin
      if (req_q.req_type == REQ_CREATE && free_found) begin
        mem_we    = 1'b1;
        mem_waddr = free_slot;
        mem_wdata = frame_addr;
      end else if (req_q.req_type == REQ_TICK) begin
        mem_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      saved_sp[mem_waddr] <= mem_wdata;
    end
    if (cmd.read) begin
      rd_data <= saved_sp[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        task_state[i] <= ST_FREE;
      end
      cur <= '0;
    end else if (cmd.exec) begin
      unique case (req_q.req_type)
        REQ_CREATE: begin
          if (free_found) begin
            task_state[free_slot] <= ST_READY;
          end
        end
        REQ_TICK: begin
          if (next_slot != cur) begin
            task_state[cur]       <= ST_READY;
            task_state[next_slot] <= ST_RUNNING;
            cur                   <= next_slot;
          end
        end
        REQ_START: begin
          task_state[0] <= ST_RUNNING;
          cur           <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result registers, set while the request executes
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      unique case (req_q.req_type)
        REQ_CREATE: begin
          res_status <= free_found ? STS_CREATED : STS_FULL;
          res_slot   <= free_found ? free_slot : '0;
          res_prev   <= '0;
          res_addr   <= free_found ? frame_addr : '0;
          rd_addr    <= '0;
        end
        REQ_TICK: begin
          res_status <= (next_slot != cur) ? STS_SWITCHED : STS_STAYED;
          res_slot   <= next_slot;
          res_prev   <= cur;
          res_addr   <= '0;
          rd_addr    <= next_slot;
        end
        REQ_START: begin
          res_status <= STS_STARTED;
          res_slot   <= '0;
          res_prev   <= '0;
          res_addr   <= '0;
          rd_addr    <= '0;
        end
        default: begin
          res_status <= STS_FULL;
          res_slot   <= '0;
          res_prev   <= '0;
          res_addr   <= '0;
          rd_addr    <= '0;
        end
      endcase
    end
  end

  always_comb begin
    rsp.status           = res_status;
    rsp.slot             = OUT_SLOT_W'(res_slot);
    rsp.prev_task        = OUT_SLOT_W'(res_prev);
    rsp.sp_value         = rd_data;
    rsp.frame_ra_word    = '0;
    rsp.frame_entry_word = '0;
    if (res_status == STS_CREATED) begin
      rsp.sp_value         = res_addr;
      rsp.frame_ra_word    = trampoline;
      rsp.frame_entry_word = req_q.entry_addr;
    end else if (res_status == STS_FULL) begin
      rsp.sp_value = '0;
    end
  end

endmodule

// ===== src/rrts_ctrl.sv =====
// Request sequencer: capture, execute, read stack pointer, respond.
`timescale 1ns / 1ps
module rrts_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output rrts_pkg::cmd_t cmd,
  input  rrts_pkg::sts_t sts
);
  import rrts_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_RESP
  } state_t;

  state_t state;

  assign busy     = (state != S_IDLE);
  assign cmd.load = (state == S_IDLE) && start;
  assign cmd.exec = (state == S_EXEC);
  assign cmd.read = (state == S_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          // drop the unused request code without a result
          state <= sts.drop ? S_IDLE : S_READ;
        end
        S_READ: begin
          state <= S_RESP;
          done  <= 1'b1;
        end
        S_RESP: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/round_robin_task_scheduler.sv =====
// A request accepted at an edge passes through the execute, stack pointer memory read
// and response steps of the sequencer, and a new request is taken only back in idle;
// unused codes go back to idle after the execute step and give no result strobe.
// Results show for one cycle on done; the receiver cannot stall.
// Reset frees every slot, makes task 0 current and clears both registers;
// saved stack pointers hold no reset value.
`timescale 1ns / 1ps
module round_robin_task_scheduler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  rrts_pkg::req_t                req,
  output logic                          done,
  output rrts_pkg::rsp_t                rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rrts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import rrts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rrts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  rrts_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== src/rrts_checker.sv =====
// Port level checks of the scheduler, bound to the top level.
`timescale 1ns / 1ps
`include "round_robin_task_scheduler_assert.svh"
module rrts_port_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input rrts_pkg::rsp_t rsp
);
  import rrts_pkg::*;

  `RRTS_ASSERT_NOW(a_done_while_busy, done, busy)
  `RRTS_ASSERT_NEXT(a_done_single, done, !done)
  `RRTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
  `RRTS_ASSERT_NOW(a_full_zero, done && rsp.status == STS_FULL,
                   rsp.slot == '0 && rsp.sp_value == '0 && rsp.frame_ra_word == '0)
  `RRTS_ASSERT_NOW(a_status_legal, done, rsp.status <= STS_STARTED)

endmodule

bind round_robin_task_scheduler rrts_port_checker u_rrts_checker (.*);
